// ----- rtl/core/aopa_pkg.sv -----
package aopa_pkg;

  // Fixed-point constants
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [30:0] Q30_ONE   = 31'd1073741824;
  localparam logic signed [36:0] EXP_LIMIT = 37'sd8589934592;
  localparam logic [35:0] Y_BIAS    = 36'd17179869184;
  localparam logic [6:0]  SHIFT_PIVOT = 7'd94;
  localparam logic [47:0] PRICE_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [62:0] ACC_MAX   = 63'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [29:0] RECIP_SIX = 30'd715827883;
  localparam logic [61:0] SQ_LIMIT  = 62'd549755813888;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_SPOT,
    CFG_STRIKE,
    CFG_DRIFT,
    CFG_DIFFUSION,
    CFG_DISCOUNT,
    CFG_IS_CALL
  } aopa_cfg_idx_e;

  // Sequencer states of the evaluation engine
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SCALE,
    ST_LOG,
    ST_SPLIT,
    ST_REDUCE,
    ST_RECIP,
    ST_CORR,
    ST_SQW,
    ST_CUBE,
    ST_DIV6,
    ST_MANT,
    ST_PROD,
    ST_PRICE,
    ST_AVG,
    ST_DISC,
    ST_SQR,
    ST_ACC
  } aopa_state_e;

  typedef struct packed {
    logic [15:0] z;
    logic        last;
  } aopa_item_t;

  typedef struct packed {
    logic [31:0]        spot;
    logic [31:0]        strike;
    logic signed [31:0] drift;
    logic [30:0]        diffusion;
    logic [31:0]        discount;
    logic               is_call;
  } aopa_cfg_t;

endpackage

// ----- rtl/core/aopa_front.sv -----
module aopa_front import aopa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] normal_sample_i,
  input  logic        last_pair_i,
  output logic        q_valid_o,
  output aopa_item_t  q_item_o,
  input  logic        q_pop_i
);

  aopa_item_t slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push;

  assign in_ready_o = (count_q != 2'd2);
  assign q_valid_o  = (count_q != 2'd0);
  assign q_item_o   = slot_q[rd_ptr_q];
  assign push       = in_valid_i & in_ready_o;

  // Store incoming transactions
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= '{z: normal_sample_i, last: last_pair_i};
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + 2'(push) - 2'(q_pop_i);
    end
  end

endmodule

// ----- rtl/core/aopa_back.sv -----
module aopa_back import aopa_pkg::*; #(
  parameter int COUNT_BITS      = 24,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  aopa_cfg_t   cfg_i,
  input  logic        q_valid_i,
  input  aopa_item_t  q_item_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [62:0] sum_payoff_o,
  output logic [62:0] sum_payoff_sq_o,
  output logic [24:0] pair_count_o,
  output logic        overflow_o
);

  localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);
  localparam int D_W   = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int FD_W  = 28 + D_W;
  localparam int CNT_W = COUNT_BITS + 1;
  localparam int PC_W  = (CNT_W > 25) ? CNT_W : 25;
  localparam logic [D_W-1:0]   DEPTH     = D_W'(EXP_TABLE_DEPTH);
  localparam logic [32:0]      RECIP_D   = 33'((64'd1 << 32) / EXP_TABLE_DEPTH);
  localparam logic [CNT_W-1:0] COUNT_MAX = {1'b1, {COUNT_BITS{1'b0}}};

  // 2^(i/D) in Q2.30 by a Taylor series through the x^12 term, built at elaboration
  function automatic logic [31:0] rom_entry(input int i);
    logic [63:0] x, t, s;
    x = (64'(i) * 64'(LN2_Q30)) / 64'(EXP_TABLE_DEPTH);
    t = 64'(Q30_ONE);
    s = t;
    t = (t * x) >> 30;        s = s + t;
    t = ((t * x) >> 30) / 2;  s = s + t;
    t = ((t * x) >> 30) / 3;  s = s + t;
    t = ((t * x) >> 30) / 4;  s = s + t;
    t = ((t * x) >> 30) / 5;  s = s + t;
    t = ((t * x) >> 30) / 6;  s = s + t;
    t = ((t * x) >> 30) / 7;  s = s + t;
    t = ((t * x) >> 30) / 8;  s = s + t;
    t = ((t * x) >> 30) / 9;  s = s + t;
    t = ((t * x) >> 30) / 10; s = s + t;
    t = ((t * x) >> 30) / 11; s = s + t;
    t = ((t * x) >> 30) / 12; s = s + t;
    return s[31:0];
  endfunction

  logic [31:0] exp_rom [EXP_TABLE_DEPTH];
  for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_rom
    assign exp_rom[g] = rom_entry(g);
  end

  aopa_state_e state_q, state_d;
  logic        phase_q, last_q, sat_q;
  logic [62:0] acc_sum_q, acc_sq_q;
  logic [CNT_W-1:0] acc_cnt_q;
  logic        out_valid_q;
  logic [62:0] out_sum_q, out_sq_q;
  logic [24:0] out_cnt_q;
  logic        out_ovf_q;

  // Datapath registers
  logic [15:0]             z_q;
  logic signed [34:0]      xa_q, xb_q;
  logic [6:0]              yhi_q;
  logic [27:0]             f_q;
  logic [IDX_W-1:0]        idx_q;
  logic [27:0]             u_q;
  logic [29:0]             v_q, q0_q, w_q, w2_q, w3_q, w3d_q;
  logic [31:0]             rom_q, mant_q;
  logic [63:0]             prod_q;
  logic [47:0]             pay0_q, pay1_q;
  logic [47:0]             hd_q;
  logic [63:0]             ld_q;
  logic [50:0]             disc_q;
  logic [61:0]             hh_q;
  logic [50:0]             hl_q;
  logic [39:0]             ll_q;

  // Scale step
  logic [15:0]        zmag;
  logic [46:0]        sprod;
  logic signed [36:0] s_sgn, drift_x, xp, xm;
  logic signed [36:0] xa_c, xb_c;
  logic               clamp_sat;

  always_comb begin
    zmag    = z_q[15] ? (16'd0 - z_q) : z_q;
    sprod   = 47'(cfg_i.diffusion) * 47'(zmag) + 47'd2048;
    s_sgn   = z_q[15] ? -$signed({2'b00, sprod[46:12]}) : $signed({2'b00, sprod[46:12]});
    drift_x = 37'(cfg_i.drift);
    xp      = drift_x + s_sgn;
    xm      = drift_x - s_sgn;
    clamp_sat = 1'b0;
    xa_c = xp;
    xb_c = xm;
    if (xp > EXP_LIMIT) begin
      xa_c = EXP_LIMIT;
      clamp_sat = 1'b1;
    end else if (xp < -EXP_LIMIT) begin
      xa_c = -EXP_LIMIT;
    end
    if (xm > EXP_LIMIT) begin
      xb_c = EXP_LIMIT;
      clamp_sat = 1'b1;
    end else if (xm < -EXP_LIMIT) begin
      xb_c = -EXP_LIMIT;
    end
  end

  // Exponent to base two, split into integer and fraction, table index, reduction and mantissa
  logic signed [34:0] x_cur;
  logic               x_neg;
  logic [33:0]        x_mag;
  logic [64:0]        ylong;
  logic [35:0]        yo;
  logic [FD_W-1:0]    fd;
  logic [57:0]        vlong;
  logic [62:0]        qlong;
  logic [42:0]        rem;
  logic [31:0]        poly;
  logic [63:0]        mlong;

  always_comb begin
    x_cur = phase_q ? xb_q : xa_q;
    x_neg = x_cur[34];
    x_mag = x_neg ? 34'(-x_cur) : 34'(x_cur);
    ylong = 65'(x_mag) * 65'(LOG2E_Q30) + (65'd1 << 29);
    yo    = x_neg ? (Y_BIAS - 36'(ylong[64:30])) : (Y_BIAS + 36'(ylong[64:30]));
    fd    = FD_W'(f_q) * FD_W'(DEPTH);
    vlong = 58'(u_q) * 58'(LN2_Q30);
    qlong = 63'(v_q) * 63'(RECIP_D);
    rem   = 43'(v_q) - 43'(q0_q) * 43'(DEPTH);
    poly  = 32'(Q30_ONE) + 32'(w_q) + 32'(w2_q >> 1) + 32'(w3d_q);
    mlong = 64'(rom_q) * 64'(poly);
  end

  // Scale to price and take the payoff
  logic        n_le30;
  logic [6:0]  rsh, lsh;
  logic [63:0] res;
  logic [47:0] price, payoff;
  logic        price_sat;

  always_comb begin
    n_le30    = (yhi_q <= SHIFT_PIVOT);
    rsh       = SHIFT_PIVOT - yhi_q;
    lsh       = yhi_q - SHIFT_PIVOT;
    price_sat = 1'b0;
    res       = 64'd0;
    if (n_le30) begin
      res = prod_q >> rsh;
    end else if (prod_q > (64'(PRICE_MAX) >> lsh)) begin
      price_sat = 1'b1;
      res       = 64'(PRICE_MAX);
    end else begin
      res = prod_q << lsh;
    end
    if (res > 64'(PRICE_MAX)) begin
      price_sat = 1'b1;
      price     = PRICE_MAX;
    end else begin
      price = res[47:0];
    end
    if (cfg_i.is_call) begin
      payoff = (price > 48'(cfg_i.strike)) ? price - 48'(cfg_i.strike) : 48'd0;
    end else begin
      payoff = (48'(cfg_i.strike) > price) ? 48'(cfg_i.strike) - price : 48'd0;
    end
  end

  // Average the pair, square and accumulate
  logic [48:0] pair_sum;
  logic [47:0] avg;
  logic [63:0] sq, sum_n, sqsum_n;
  logic        sq_sat, sum_sat, sqsum_sat, cnt_sat, acc_go;
  logic [62:0] sq_c, sum_c, sqsum_c;
  logic [CNT_W-1:0] cnt_c;
  logic [PC_W-1:0]  cnt_ext;

  always_comb begin
    pair_sum = 49'(pay0_q) + 49'(pay1_q);
    avg      = pair_sum[48:1];
    sq       = (64'(hh_q) << 24) + (64'(hl_q) << 5) + 64'(ll_q >> 16);
    sq_sat   = (hh_q >= SQ_LIMIT) || (sq > 64'(ACC_MAX));
    sq_c     = sq_sat ? ACC_MAX : sq[62:0];
    sum_n    = 64'(acc_sum_q) + 64'(disc_q);
    sum_sat  = sum_n > 64'(ACC_MAX);
    sum_c    = sum_sat ? ACC_MAX : sum_n[62:0];
    sqsum_n  = 64'(acc_sq_q) + 64'(sq_c);
    sqsum_sat = sqsum_n > 64'(ACC_MAX);
    sqsum_c  = sqsum_sat ? ACC_MAX : sqsum_n[62:0];
    cnt_sat  = acc_cnt_q >= COUNT_MAX;
    cnt_c    = cnt_sat ? COUNT_MAX : acc_cnt_q + CNT_W'(1);
    cnt_ext  = PC_W'(cnt_c);
    acc_go   = !(last_q && out_valid_q && !out_ready_i);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          state_d = ST_SCALE;
        end
      end
      ST_SCALE:  state_d = ST_LOG;
      ST_LOG:    state_d = ST_SPLIT;
      ST_SPLIT:  state_d = ST_REDUCE;
      ST_REDUCE: state_d = ST_RECIP;
      ST_RECIP:  state_d = ST_CORR;
      ST_CORR:   state_d = ST_SQW;
      ST_SQW:    state_d = ST_CUBE;
      ST_CUBE:   state_d = ST_DIV6;
      ST_DIV6:   state_d = ST_MANT;
      ST_MANT:   state_d = ST_PROD;
      ST_PROD:   state_d = ST_PRICE;
      ST_PRICE:  state_d = phase_q ? ST_AVG : ST_LOG;
      ST_AVG:    state_d = ST_DISC;
      ST_DISC:   state_d = ST_SQR;
      ST_SQR:    state_d = ST_ACC;
      ST_ACC: begin
        if (acc_go) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath step registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        z_q    <= q_item_i.z;
        last_q <= q_item_i.last;
      end
      ST_SCALE: begin
        xa_q <= 35'(xa_c);
        xb_q <= 35'(xb_c);
      end
      ST_LOG: begin
        yhi_q <= yo[34:28];
        f_q   <= yo[27:0];
      end
      ST_SPLIT: begin
        idx_q <= fd[28 +: IDX_W];
        u_q   <= fd[27:0];
      end
      ST_REDUCE: begin
        v_q   <= vlong[57:28];
        rom_q <= exp_rom[idx_q];
      end
      ST_RECIP:  q0_q <= qlong[61:32];
      ST_CORR:   w_q <= q0_q + 30'(rem >= 43'(DEPTH));
      ST_SQW:    w2_q <= 30'((60'(w_q) * 60'(w_q)) >> 30);
      ST_CUBE:   w3_q <= 30'((60'(w2_q) * 60'(w_q)) >> 30);
      ST_DIV6:   w3d_q <= 30'((60'(w3_q) * 60'(RECIP_SIX)) >> 32);
      ST_MANT:   mant_q <= mlong[61:30];
      ST_PROD:   prod_q <= 64'(cfg_i.spot) * 64'(mant_q);
      ST_PRICE: begin
        if (phase_q) pay1_q <= payoff;
        else         pay0_q <= payoff;
      end
      ST_AVG: begin
        hd_q <= 48'(avg[47:32]) * 48'(cfg_i.discount);
        ld_q <= 64'(avg[31:0]) * 64'(cfg_i.discount);
      end
      ST_DISC:   disc_q <= (51'(hd_q) << 1) + 51'(ld_q >> 31);
      ST_SQR: begin
        hh_q <= 62'(disc_q[50:20]) * 62'(disc_q[50:20]);
        hl_q <= 51'(disc_q[50:20]) * 51'(disc_q[19:0]);
        ll_q <= 40'(disc_q[19:0]) * 40'(disc_q[19:0]);
      end
      ST_ACC: begin
        if (acc_go && last_q) begin
          out_sum_q <= sum_c;
          out_sq_q  <= sqsum_c;
          out_cnt_q <= cnt_ext[24:0];
          out_ovf_q <= sat_q | sq_sat | sum_sat | sqsum_sat | cnt_sat;
        end
      end
      default: ;
    endcase
  end

  // Control, accumulators and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= 1'b0;
      sat_q       <= 1'b0;
      acc_sum_q   <= '0;
      acc_sq_q    <= '0;
      acc_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (state_q == ST_SCALE && clamp_sat) sat_q <= 1'b1;
      if (state_q == ST_PRICE) begin
        phase_q <= ~phase_q;
        if (price_sat) sat_q <= 1'b1;
      end
      if (state_q == ST_ACC && acc_go) begin
        if (last_q) begin
          acc_sum_q   <= '0;
          acc_sq_q    <= '0;
          acc_cnt_q   <= '0;
          sat_q       <= 1'b0;
          out_valid_q <= 1'b1;
        end else begin
          acc_sum_q <= sum_c;
          acc_sq_q  <= sqsum_c;
          acc_cnt_q <= cnt_c;
          sat_q     <= sat_q | sq_sat | sum_sat | sqsum_sat | cnt_sat;
        end
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sum_payoff_o    = out_sum_q;
  assign sum_payoff_sq_o = out_sq_q;
  assign pair_count_o    = out_cnt_q;
  assign overflow_o      = out_ovf_q;

endmodule

// ----- rtl/core/antithetic_option_payoff_accumulator_core.sv -----
// Channel   Handshake                  Payload
// input     in_valid_i / in_ready_o    normal_sample_i, last_pair_i
// result    out_valid_o / out_ready_i  sum_payoff_o, sum_payoff_sq_o, pair_count_o, overflow_o
// config    cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// Each sample passes through the evaluation engine in order: it is taken from
// the queue, scaled, priced twice through the exp sequencer, and then
// discounted, squared and accumulated.
// A two-entry queue takes samples while the engine works; a result waits in
// its output register and stalls the engine only when a second result is due.
// Reset (rst_ni low) empties the queue, clears the accumulators and loads the config defaults.
module antithetic_option_payoff_accumulator_core import aopa_pkg::*; #(
  parameter int COUNT_BITS      = 24,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] normal_sample_i,
  input  logic        last_pair_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [62:0] sum_payoff_o,
  output logic [62:0] sum_payoff_sq_o,
  output logic [24:0] pair_count_o,
  output logic        overflow_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  aopa_cfg_t  cfg_q;
  aopa_item_t q_item;
  logic       q_valid, q_pop;

  assign cfg_ready_o = 1'b1;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.spot      <= 32'd6553600;
      cfg_q.strike    <= 32'd6553600;
      cfg_q.drift     <= '0;
      cfg_q.diffusion <= '0;
      cfg_q.discount  <= 32'h8000_0000;
      cfg_q.is_call   <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_SPOT:      cfg_q.spot      <= cfg_data_i;
        CFG_STRIKE:    cfg_q.strike    <= cfg_data_i;
        CFG_DRIFT:     cfg_q.drift     <= $signed(cfg_data_i);
        CFG_DIFFUSION: cfg_q.diffusion <= cfg_data_i[30:0];
        CFG_DISCOUNT:  cfg_q.discount  <= cfg_data_i;
        CFG_IS_CALL:   cfg_q.is_call   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  aopa_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .normal_sample_i(normal_sample_i),
    .last_pair_i    (last_pair_i),
    .q_valid_o      (q_valid),
    .q_item_o       (q_item),
    .q_pop_i        (q_pop)
  );

  aopa_back #(
    .COUNT_BITS     (COUNT_BITS),
    .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_valid_i      (q_valid),
    .q_item_i       (q_item),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sum_payoff_o   (sum_payoff_o),
    .sum_payoff_sq_o(sum_payoff_sq_o),
    .pair_count_o   (pair_count_o),
    .overflow_o     (overflow_o)
  );

  // The engine never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  // An accepted sample leaves the queue occupied
  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> q_valid)
    else $error("accepted sample lost");

endmodule
